@@ hw/rtl/scd_pkg.sv @@
// saturation contact detector: shared types and constants
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps
package scd_pkg;

   localparam int unsigned LimitW    = 16;
   localparam int unsigned SwatW     = 16;
   localparam int unsigned CoordW    = 32;
   localparam int unsigned DepthOutW = 31;
   localparam int unsigned RiseW     = 17;
   localparam int unsigned DenW      = 17;
   localparam int unsigned MagW      = 32;
   localparam int unsigned ProdW     = 48;
   localparam int unsigned AluW      = 50;
   localparam int unsigned MulSteps  = 16;
   localparam int unsigned DivSteps  = 48;
   localparam int unsigned StepW     = 6;

   localparam logic [LimitW-1:0]    LimitReset = 16'd6554;
   localparam logic [DepthOutW-1:0] DepthMax   = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_EMIT
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [AluW-1:0]     opa;
      logic [AluW-1:0]     opb;
   } alu_req_type;

endpackage

@@ hw/rtl/scd_alu.sv @@
// saturation contact detector: shared add/subtract unit
// serves multiply, divide and final depth steps; uses scd_pkg
`timescale 1ns / 1ps
module scd_alu
   import scd_pkg::*;
(
   input  alu_req_type      alu_req,
   output logic [AluW-1:0]  alu_sum
);

   always_comb begin
      case (alu_req.op)
         ALU_ADD: alu_sum = alu_req.opa + alu_req.opb;
         ALU_SUB: alu_sum = alu_req.opa - alu_req.opb;
         default: alu_sum = alu_req.opa + alu_req.opb;
      endcase
   end

endmodule

@@ hw/rtl/saturation_contact_detector_core.sv @@
// saturation contact detector: top level with sequencer and column state
// depends on scd_pkg and scd_alu
`timescale 1ns / 1ps
// usage
//   req channel: one beat per grid cell of a column, top to bottom,
//   last_in_column marks the bottom cell. rsp channel: at most one beat per
//   column with x, y of the detecting cell and the positive contact depth.
//   csr channel: write data is the rise limit, taken while csr_ready is high,
//   which is whenever no cell is in work.
// sequencing
//   no new cell is taken until the current one is done. a non-detecting
//   cell ends after its check; a detecting one without a usable cell above
//   goes to the depth step, with interpolation after 16 shift-add multiply
//   and 48 restoring divide steps, all on the one shared 50 bit adder.
// reset
//   synchronous, active high; limit returns to 6554, column state clears,
//   rsp_valid drops.
// stall
//   a waiting result sits in the output register while the next cells are
//   taken; only a further result holds the sequencer until the slot frees.
module saturation_contact_detector_core
   import scd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cell_active,
   input  logic [SwatW-1:0]            req_swat_base,
   input  logic [SwatW-1:0]            req_swat_monitor,
   input  logic signed [CoordW-1:0]    req_cell_x,
   input  logic signed [CoordW-1:0]    req_cell_y,
   input  logic signed [CoordW-1:0]    req_cell_depth,
   input  logic                        req_last_in_column,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [CoordW-1:0]    rsp_contact_x,
   output logic signed [CoordW-1:0]    rsp_contact_y,
   output logic [DepthOutW-1:0]        rsp_contact_depth,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [LimitW-1:0]           csr_rise_limit
);

   state_type state_ff, state_in;

   logic [LimitW-1:0]        limit_ff, limit_in;

   logic                     item_active_ff;
   logic [SwatW-1:0]         item_base_ff, item_monitor_ff;
   logic [CoordW-1:0]        item_x_ff, item_y_ff, item_z_ff;
   logic                     item_last_ff;

   logic                     above_active_ff, above_active_in;
   logic [RiseW-1:0]         above_rise_ff, above_rise_in;
   logic [CoordW-1:0]        above_depth_ff, above_depth_in;
   logic                     found_ff, found_in;

   logic [ProdW-1:0]         acc_ff, acc_in;
   logic [LimitW-1:0]        amag_ff, amag_in;
   logic [MagW-1:0]          bmag_ff, bmag_in;
   logic                     bneg_ff, bneg_in;
   logic [DenW-1:0]          den_ff, den_in;
   logic [DenW-1:0]          rem_ff, rem_in;
   logic [StepW-1:0]         step_ff, step_in;
   logic [DepthOutW-1:0]     depth_ff, depth_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CoordW-1:0]        rsp_x_ff, rsp_y_ff;
   logic [DepthOutW-1:0]     rsp_depth_ff;

   logic                     req_take;
   logic                     csr_take;
   logic                     slot_free;
   logic                     rsp_load;
   logic                     step_last;

   logic [RiseW-1:0]         rise;
   logic                     detect;
   logic [RiseW:0]           den_full;
   logic                     interp;
   logic [RiseW-1:0]         amag_full;
   logic [CoordW:0]          bdiff;
   logic [CoordW:0]          bdiff_mag;
   logic                     depth_pos;
   logic                     depth_over;

   alu_req_type              alu_req;
   logic [AluW-1:0]          alu_sum;

   scd_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   // cell evaluation on the held beat
   assign rise      = RiseW'({1'b0, item_monitor_ff}) - RiseW'({1'b0, item_base_ff});
   assign detect    = item_active_ff &&
                      ($signed({rise[RiseW-1], rise}) > $signed({2'b00, limit_ff}));
   assign den_full  = {rise[RiseW-1], rise} - {above_rise_ff[RiseW-1], above_rise_ff};
   assign interp    = above_active_ff && !den_full[RiseW] && (den_full != '0);
   assign amag_full = rise - RiseW'({1'b0, limit_ff});
   assign bdiff     = {item_z_ff[CoordW-1], item_z_ff} -
                      {above_depth_ff[CoordW-1], above_depth_ff};
   assign bdiff_mag = bdiff[CoordW] ? (~bdiff + 1'b1) : bdiff;

   assign depth_pos  = !alu_sum[AluW-1] && (alu_sum != '0);
   assign depth_over = (alu_sum[AluW-2:DepthOutW] != '0);

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign step_last = (state_ff == ST_MUL) ? (step_ff == StepW'(MulSteps - 1))
                                           : (step_ff == StepW'(DivSteps - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (found_ff || !detect) state_in = ST_IDLE;
            else if (interp)         state_in = ST_MUL;
            else                     state_in = ST_FIX;
         end
         ST_MUL: begin
            if (step_last) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_last) state_in = ST_FIX;
         end
         ST_FIX: begin
            if (depth_pos) state_in = ST_EMIT;
            else           state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs and shared unit selection
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      csr_ready   = (state_ff == ST_IDLE);
      rsp_load    = (state_ff == ST_EMIT) && slot_free;
      alu_req.op  = ALU_ADD;
      alu_req.opa = '0;
      alu_req.opb = '0;
      case (state_ff)
         ST_MUL: begin
            alu_req.op  = ALU_ADD;
            alu_req.opa = AluW'({acc_ff[ProdW-2:0], 1'b0});
            alu_req.opb = amag_ff[LimitW-1] ? AluW'(bmag_ff) : '0;
         end
         ST_DIV: begin
            alu_req.op  = ALU_SUB;
            alu_req.opa = AluW'({rem_ff, acc_ff[ProdW-1]});
            alu_req.opb = AluW'(den_ff);
         end
         ST_FIX: begin
            alu_req.op  = bneg_ff ? ALU_ADD : ALU_SUB;
            alu_req.opa = {{(AluW - CoordW){item_z_ff[CoordW-1]}}, item_z_ff};
            alu_req.opb = AluW'(acc_ff);
         end
         default: begin
            alu_req.op  = ALU_ADD;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      limit_in        = csr_take ? csr_rise_limit : limit_ff;
      above_active_in = above_active_ff;
      above_rise_in   = above_rise_ff;
      above_depth_in  = above_depth_ff;
      found_in        = found_ff;
      acc_in          = acc_ff;
      amag_in         = amag_ff;
      bmag_in         = bmag_ff;
      bneg_in         = bneg_ff;
      den_in          = den_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      depth_in        = depth_ff;
      rsp_valid_in    = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      case (state_ff)
         ST_CHECK: begin
            if (!found_ff) begin
               above_active_in = item_active_ff;
               above_rise_in   = rise;
               above_depth_in  = item_z_ff;
               found_in        = detect;
            end
            if (item_last_ff) begin
               above_active_in = 1'b0;
               above_rise_in   = '0;
               above_depth_in  = '0;
               found_in        = 1'b0;
            end
            acc_in  = '0;
            amag_in = amag_full[LimitW-1:0];
            bmag_in = bdiff_mag[MagW-1:0];
            bneg_in = bdiff[CoordW];
            den_in  = den_full[DenW-1:0];
            rem_in  = '0;
            step_in = '0;
         end
         ST_MUL: begin
            acc_in  = alu_sum[ProdW-1:0];
            amag_in = {amag_ff[LimitW-2:0], 1'b0};
            step_in = step_last ? '0 : step_ff + 1'b1;
         end
         ST_DIV: begin
            if (!alu_sum[AluW-1]) begin
               rem_in = alu_sum[DenW-1:0];
            end else begin
               rem_in = {rem_ff[DenW-2:0], acc_ff[ProdW-1]};
            end
            acc_in  = {acc_ff[ProdW-2:0], !alu_sum[AluW-1]};
            step_in = step_ff + 1'b1;
         end
         ST_FIX: begin
            depth_in = depth_over ? DepthMax : alu_sum[DepthOutW-1:0];
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         limit_ff        <= LimitReset;
         above_active_ff <= 1'b0;
         above_rise_ff   <= '0;
         above_depth_ff  <= '0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         step_ff         <= '0;
      end else begin
         state_ff        <= state_in;
         limit_ff        <= limit_in;
         above_active_ff <= above_active_in;
         above_rise_ff   <= above_rise_in;
         above_depth_ff  <= above_depth_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
         step_ff         <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_active_ff  <= req_cell_active;
         item_base_ff    <= req_swat_base;
         item_monitor_ff <= req_swat_monitor;
         item_x_ff       <= req_cell_x;
         item_y_ff       <= req_cell_y;
         item_z_ff       <= req_cell_depth;
         item_last_ff    <= req_last_in_column;
      end
      acc_ff   <= acc_in;
      amag_ff  <= amag_in;
      bmag_ff  <= bmag_in;
      bneg_ff  <= bneg_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      depth_ff <= depth_in;
      if (rsp_load) begin
         rsp_x_ff     <= item_x_ff;
         rsp_y_ff     <= item_y_ff;
         rsp_depth_ff <= depth_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_contact_x     = rsp_x_ff;
   assign rsp_contact_y     = rsp_y_ff;
   assign rsp_contact_depth = rsp_depth_ff;

endmodule

@@ hw/rtl/scd_checker.sv @@
// saturation contact detector: port checker and its bind to the top level
// depends on scd_pkg and saturation_contact_detector_core
`timescale 1ns / 1ps
module scd_checker
   import scd_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [CoordW-1:0]    rsp_contact_x,
   input logic signed [CoordW-1:0]    rsp_contact_y,
   input logic [DepthOutW-1:0]        rsp_contact_depth,
   input logic                        csr_ready
);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_contact_depth) &&
                                 $stable(rsp_contact_x) && $stable(rsp_contact_y))
      else $error("rsp beat changed while stalled");

   // reported depth is always positive
   a_depth_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_contact_depth != '0)
      else $error("zero contact depth reported");

   // an accepted cell keeps the block busy in the cycle after it is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !csr_ready)
      else $error("cell accepted back to back");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind saturation_contact_detector_core scd_checker u_scd_checker (.*);
